FILE: hdl/mmrs_pkg.sv
// Shared widths, codes and controller/datapath handshake types for the row-stream multiplier.
`default_nettype none

package mmrs_pkg;

   localparam int VALUE_W     = 16;
   localparam int PRODUCT_W   = 36;
   localparam int MUL_W       = 32;
   localparam int INDEX_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // Element command codes.
   localparam logic CMD_B_ELEMENT = 1'b0;
   localparam logic CMD_A_ELEMENT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_A_ROWS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_B_COLS     = 2'd2;

   typedef struct packed {
      logic b_write;
      logic a_load;
      logic issue;
      logic a_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic advance;
      logic pipe_empty;
      logic k_last;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/mmrs_if.sv
// Channel interfaces: element input, result output and configuration write.
`default_nettype none

interface mmrs_req_if import mmrs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [VALUE_W-1:0]  element_value;

   modport source (output valid, output command, output element_value, input ready);
   modport sink   (input valid, input command, input element_value, output ready);
endinterface

interface mmrs_rsp_if import mmrs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [INDEX_W-1:0]           row_index;
   logic [INDEX_W-1:0]           column_index;
   logic signed [PRODUCT_W-1:0]  product_value;
   logic                         row_last;
   logic                         matrix_last;

   modport source (output valid, output row_index, output column_index,
                   output product_value, output row_last, output matrix_last,
                   input ready);
   modport sink   (input valid, input row_index, input column_index,
                   input product_value, input row_last, input matrix_last,
                   output ready);
endinterface

interface mmrs_csr_if import mmrs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_INDEX_W-1:0]  index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mmrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/mmrs_ctrl.sv
// Controller state machine: accepts elements and sequences one A element's column walk.
`default_nettype none

module mmrs_ctrl import mmrs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_command,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_A_ELEMENT) begin
                  cmd.a_load = 1'b1;
                  state_in   = ST_RUN;
               end else begin
                  cmd.b_write = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.advance && status.k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.a_done = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mmrs_datapath.sv
// Datapath: configuration, positions, B store, accumulator store, MAC pipeline and result register.
`default_nettype none

module mmrs_datapath import mmrs_pkg::*; #(
   parameter int MAX_DIM = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ctrl_cmd_type                 cmd,
   output dp_status_type                     status,
   input  wire logic                         csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data,
   input  wire logic signed [VALUE_W-1:0]    req_element_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [INDEX_W-1:0]                rsp_row_index,
   output logic [INDEX_W-1:0]                rsp_column_index,
   output logic signed [PRODUCT_W-1:0]       rsp_product_value,
   output logic                              rsp_row_last,
   output logic                              rsp_matrix_last
);

   localparam int KW        = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int AW        = $clog2(MAX_DIM * MAX_DIM);
   localparam int PW        = 2 * DIM_W;
   localparam int DIM_RESET = (MAX_DIM < 4) ? MAX_DIM : 4;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (8'(v) > 8'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // Configuration and positions.
   logic [DIM_W-1:0] a_rows_ff, a_rows_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] b_cols_ff, b_cols_in;
   logic [AW-1:0]    b_pos_ff, b_pos_in;
   logic [AW-1:0]    b_base_ff, b_base_in;
   logic [KW-1:0]    col_ff, col_in;
   logic [KW-1:0]    row_ff, row_in;
   logic [KW-1:0]    k_ff, k_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [MAX_DIM-1:0] acc_valid_ff, acc_valid_in;

   // Pipeline stage 1: RAM read data is valid.
   logic          s1_valid_ff, s1_valid_in;
   logic [KW-1:0] s1_k_ff, s1_k_in;
   logic          s1_emit_ff, s1_emit_in;
   logic          s1_rlast_ff, s1_rlast_in;
   logic          s1_hit_ff, s1_hit_in;

   // Pipeline stage 2: product and old sum registered.
   logic                        s2_valid_ff, s2_valid_in;
   logic [KW-1:0]               s2_k_ff, s2_k_in;
   logic                        s2_emit_ff, s2_emit_in;
   logic                        s2_rlast_ff, s2_rlast_in;
   logic signed [MUL_W-1:0]     s2_prod_ff, s2_prod_in;
   logic signed [PRODUCT_W-1:0] s2_acc_ff, s2_acc_in;

   // Result register.
   logic                        out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]          out_row_ff, out_row_in;
   logic [INDEX_W-1:0]          out_col_ff, out_col_in;
   logic signed [PRODUCT_W-1:0] out_value_ff, out_value_in;
   logic                        out_rlast_ff, out_rlast_in;
   logic                        out_mlast_ff, out_mlast_in;

   logic                        advance;
   logic                        issue_go;
   logic                        last_col;
   logic                        k_last;
   logic                        csr_hit;
   logic [PW-1:0]               b_total;
   logic [PW-1:0]               b_pos_next;
   logic signed [PRODUCT_W-1:0] sum;
   logic [VALUE_W-1:0]          b_rd_data;
   logic [PRODUCT_W-1:0]        acc_rd_data;
   logic                        acc_wr_en;

   assign advance    = !(out_valid_ff && !rsp_ready);
   assign issue_go   = cmd.issue && advance;
   assign last_col   = (DIM_W'(col_ff) + DIM_W'(1)) == inner_ff;
   assign k_last     = DIM_W'(k_ff) == (b_cols_ff - DIM_W'(1));
   assign b_total    = PW'(inner_ff) * PW'(b_cols_ff);
   assign b_pos_next = PW'(b_pos_ff) + PW'(1);
   assign sum        = s2_acc_ff + PRODUCT_W'(s2_prod_ff);
   assign acc_wr_en  = advance && s2_valid_ff && !s2_emit_ff;
   assign csr_hit    = csr_valid && (csr_index == REG_A_ROWS || csr_index == REG_INNER_SIZE ||
                                     csr_index == REG_B_COLS);

   assign status.advance    = advance;
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign status.k_last     = k_last;

   mmrs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (cmd.b_write),
      .wr_addr (b_pos_ff),
      .wr_data (req_element_value),
      .rd_en   (advance),
      .rd_addr (AW'(b_base_ff + AW'(k_ff))),
      .rd_data (b_rd_data)
   );

   mmrs_ram #(
      .WIDTH (PRODUCT_W),
      .DEPTH (MAX_DIM)
   ) u_acc_store (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (s2_k_ff),
      .wr_data (sum),
      .rd_en   (advance),
      .rd_addr (k_ff),
      .rd_data (acc_rd_data)
   );

   always_comb begin
      a_rows_in    = a_rows_ff;
      inner_in     = inner_ff;
      b_cols_in    = b_cols_ff;
      b_pos_in     = b_pos_ff;
      b_base_in    = b_base_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      value_in     = value_ff;
      acc_valid_in = acc_valid_ff;

      s1_valid_in  = s1_valid_ff;
      s1_k_in      = s1_k_ff;
      s1_emit_in   = s1_emit_ff;
      s1_rlast_in  = s1_rlast_ff;
      s1_hit_in    = s1_hit_ff;
      s2_valid_in  = s2_valid_ff;
      s2_k_in      = s2_k_ff;
      s2_emit_in   = s2_emit_ff;
      s2_rlast_in  = s2_rlast_ff;
      s2_prod_in   = s2_prod_ff;
      s2_acc_in    = s2_acc_ff;

      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_value_in = out_value_ff;
      out_rlast_in = out_rlast_ff;
      out_mlast_in = out_mlast_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_A_ROWS:     a_rows_in = clamp_dim(csr_data);
            REG_INNER_SIZE: inner_in  = clamp_dim(csr_data);
            REG_B_COLS:     b_cols_in = clamp_dim(csr_data);
            default: ;
         endcase
      end

      if (cmd.a_load) begin
         value_in = req_element_value;
         k_in     = '0;
      end

      // Stage 1 capture.
      if (advance) begin
         s1_valid_in = issue_go;
         s1_k_in     = k_ff;
         s1_emit_in  = last_col;
         s1_rlast_in = k_last;
         s1_hit_in   = acc_valid_ff[k_ff];
      end
      if (issue_go) begin
         k_in = KW'(k_ff + KW'(1));
      end

      // Stage 2 capture.
      if (advance) begin
         s2_valid_in = s1_valid_ff;
         s2_k_in     = s1_k_ff;
         s2_emit_in  = s1_emit_ff;
         s2_rlast_in = s1_rlast_ff;
         s2_prod_in  = value_ff * $signed(b_rd_data);
         s2_acc_in   = s1_hit_ff ? $signed(acc_rd_data) : '0;
      end

      // Retire: write the sum back, or hand it to the result register and
      // mark that accumulator empty again.
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && s2_valid_ff) begin
         if (s2_emit_ff) begin
            acc_valid_in[s2_k_ff] = 1'b0;
            out_valid_in = 1'b1;
            out_row_in   = INDEX_W'(row_ff);
            out_col_in   = INDEX_W'(s2_k_ff);
            out_value_in = sum;
            out_rlast_in = s2_rlast_ff;
            out_mlast_in = s2_rlast_ff && ((DIM_W'(row_ff) + DIM_W'(1)) == a_rows_ff);
         end else begin
            acc_valid_in[s2_k_ff] = 1'b1;
         end
      end

      if (cmd.a_done) begin
         if (last_col) begin
            col_in    = '0;
            b_base_in = '0;
            if ((DIM_W'(row_ff) + DIM_W'(1)) == a_rows_ff) begin
               row_in = '0;
            end else begin
               row_in = KW'(row_ff + KW'(1));
            end
         end else begin
            col_in    = KW'(col_ff + KW'(1));
            b_base_in = AW'(PW'(b_base_ff) + PW'(b_cols_ff));
         end
      end

      if (cmd.b_write) begin
         b_pos_in = (b_pos_next >= b_total) ? '0 : AW'(b_pos_next);
      end
      if (csr_hit) begin
         b_pos_in = '0;
      end

      // Any B write or register write restarts the A walk.
      if (cmd.b_write || csr_hit) begin
         col_in       = '0;
         row_in       = '0;
         b_base_in    = '0;
         acc_valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= DIM_W'(DIM_RESET);
         inner_ff     <= DIM_W'(DIM_RESET);
         b_cols_ff    <= DIM_W'(DIM_RESET);
         b_pos_ff     <= '0;
         b_base_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         acc_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_rows_ff    <= a_rows_in;
         inner_ff     <= inner_in;
         b_cols_ff    <= b_cols_in;
         b_pos_ff     <= b_pos_in;
         b_base_ff    <= b_base_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         acc_valid_ff <= acc_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      s1_k_ff      <= s1_k_in;
      s1_emit_ff   <= s1_emit_in;
      s1_rlast_ff  <= s1_rlast_in;
      s1_hit_ff    <= s1_hit_in;
      s2_k_ff      <= s2_k_in;
      s2_emit_ff   <= s2_emit_in;
      s2_rlast_ff  <= s2_rlast_in;
      s2_prod_ff   <= s2_prod_in;
      s2_acc_ff    <= s2_acc_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_value_ff <= out_value_in;
      out_rlast_ff <= out_rlast_in;
      out_mlast_ff <= out_mlast_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_row_index     = out_row_ff;
   assign rsp_column_index  = out_col_ff;
   assign rsp_product_value = out_value_ff;
   assign rsp_row_last      = out_rlast_ff;
   assign rsp_matrix_last   = out_mlast_ff;

endmodule

`default_nettype wire

FILE: hdl/matrix_multiply_row_stream.sv
// Top level of the streaming row-by-row matrix multiplier.
//
// Usage: write a_rows, inner_size and b_cols on the csr channel while the block is
// idle; each write restarts the B and A positions and clears the accumulators.
// Then send the inner_size*b_cols elements of B (command 0) in row-major order,
// followed by A elements (command 1) in row-major order, all signed Q8.8.
// A B beat is taken while the controller is idle and also restarts the A walk.
// For an A beat, one multiply-accumulate per cycle, held while the receiver stalls, walks the
// b_cols accumulators through the B store and accumulator RAM read ports, then
// two pipeline stages drain and the controller returns to idle before the next
// beat is taken. That MAC loop sets the rate, so the next A beat waits until the
// last one has drained. On the last column of an A row, the b_cols elements of
// that C row leave on the rsp channel as exact Q20.16 sums, each passing through
// stage 1, stage 2 and the result register, with row_last on the final column
// and matrix_last on the last row.
// When the receiver stalls, the result register holds and the MAC pipeline
// freezes with it; nothing is dropped. Synchronous reset empties the pipeline,
// sets all three dimensions to 4 and clears the positions and accumulators;
// the B store keeps no reset value and must be written before it is used.
`default_nettype none

module matrix_multiply_row_stream import mmrs_pkg::*; #(
   parameter int MAX_DIM = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   mmrs_req_if.sink   req_bus,
   mmrs_rsp_if.source rsp_bus,
   mmrs_csr_if.sink   csr_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration writes are always taken.
   assign csr_bus.ready = 1'b1;

   mmrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   mmrs_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .req_element_value (req_bus.element_value),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_row_index     (rsp_bus.row_index),
      .rsp_column_index  (rsp_bus.column_index),
      .rsp_product_value (rsp_bus.product_value),
      .rsp_row_last      (rsp_bus.row_last),
      .rsp_matrix_last   (rsp_bus.matrix_last)
   );

endmodule

`default_nettype wire

FILE: hdl/mmrs_checker.sv
// Port-level assertions for the row-stream multiplier and their bind to the top level.
`default_nettype none

module mmrs_checker import mmrs_pkg::*; (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [INDEX_W-1:0]          row_index,
   input wire logic [INDEX_W-1:0]          column_index,
   input wire logic signed [PRODUCT_W-1:0] product_value,
   input wire logic                        row_last,
   input wire logic                        matrix_last
);

   logic               rsp_beat;
   logic [INDEX_W-1:0] exp_col_ff;
   logic [INDEX_W-1:0] exp_col_in;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      exp_col_in = exp_col_ff;
      if (rsp_beat) begin
         exp_col_in = row_last ? '0 : INDEX_W'(column_index + INDEX_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_col_ff <= '0;
      end else begin
         exp_col_ff <= exp_col_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(product_value) &&
                                  $stable(column_index) && $stable(row_index))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_column_order: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> column_index == exp_col_ff)
      else $error("result columns out of order");

   a_matrix_end: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && matrix_last |-> row_last)
      else $error("matrix end flagged off a row end");

endmodule

bind matrix_multiply_row_stream mmrs_checker u_mmrs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .row_index     (rsp_bus.row_index),
   .column_index  (rsp_bus.column_index),
   .product_value (rsp_bus.product_value),
   .row_last      (rsp_bus.row_last),
   .matrix_last   (rsp_bus.matrix_last)
);

`default_nettype wire
